[rtl/core/lru_pkg.sv]
// lru_pkg: widths and constants shared by the LRU page replacement unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

  // Configuration register and result field widths
  localparam int unsigned FRAME_COUNT_W = 4;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned COUNT_W       = 32;

  // Frame count after reset
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 4'd8;

  // Saturation value of the hit and fault totals
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage : lru_pkg

`default_nettype wire

[rtl/core/lru_ram.sv]
// lru_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lru_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : lru_ram

`default_nettype wire

[rtl/core/lru_page_replacement_unit.sv]
// lru_page_replacement_unit: LRU page replacement over a small set of frames.
// Uses lru_pkg for widths and constants, and lru_ram for page and rank storage.
`timescale 1ns / 1ps
`default_nettype none
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ------------------------------------------
//   in        input      in_valid / in_stall  page
//   out       output     out_valid/out_stall  hit, slot, replaced_valid, replaced_page,
//                                             hits_total, faults_total
//   cfg       input      cfg_we               cfg_wdata (frame_count)
//
// One item takes one pass over the first n frames of the page and rank memories to
// search, then a second pass over the rank memory to age the frames, n being the
// active frame count; each memory read port serves one frame per cycle. No new item
// is accepted until the result of the last one is loaded.
// Synchronous reset clears frame valid bits, totals and the sequencer; frame_count
// returns to 8. The result register lets the next item be accepted while a result
// still waits; the sequencer holds the next result until that one is transferred.

module lru_page_replacement_unit #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [lru_pkg::FRAME_COUNT_W-1:0]  cfg_wdata,
  // page reference input
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [PAGE_BITS-1:0]               page,
  // result output
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    hit,
  output logic      [lru_pkg::SLOT_W-1:0]         slot,
  output logic                                    replaced_valid,
  output logic      [PAGE_BITS-1:0]               replaced_page,
  output logic      [lru_pkg::COUNT_W-1:0]        hits_total,
  output logic      [lru_pkg::COUNT_W-1:0]        faults_total
);

  import lru_pkg::*;

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1; // frame index
  localparam int unsigned RW = IW;                                // rank
  localparam int unsigned LW = RW + 1;                            // rank limit
  localparam int unsigned CW = $clog2(FRAMES + 1);                // frame count

  localparam logic [RW-1:0] RANK_TOP   = RW'(FRAMES - 1);
  localparam logic [LW-1:0] LIMIT_FULL = LW'(FRAMES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [FRAME_COUNT_W-1:0] frame_count;
  logic [FRAMES-1:0]      frame_valid;
  logic [COUNT_W-1:0]     hit_counter;
  logic [COUNT_W-1:0]     fault_counter;

  logic [PAGE_BITS-1:0]   page_q;
  logic [CW-1:0]          n_act;
  logic [CW-1:0]          rd_idx;
  logic                   chk_vld;
  logic [IW-1:0]          chk_idx;

  // search results
  logic                   hit_found;
  logic [IW-1:0]          hit_idx;
  logic [RW-1:0]          hit_rank;
  logic                   empty_found;
  logic [IW-1:0]          empty_idx;
  logic [IW-1:0]          max_idx;
  logic [RW-1:0]          max_rank;
  logic [PAGE_BITS-1:0]   max_page;

  // decision for the update pass
  logic                   is_hit;
  logic                   is_repl;
  logic [IW-1:0]          slot_idx;
  logic [LW-1:0]          limit;
  logic [PAGE_BITS-1:0]   repl_page;

  logic [PAGE_BITS-1:0]   page_rdata;
  logic [RW-1:0]          rank_rdata;

  logic                   issue;
  logic                   pass_done;
  logic                   in_xfer;
  logic                   out_free;
  logic                   chk_valid_bit;
  logic [CW-1:0]          n_req;

  logic                   dec_hit;
  logic                   dec_repl;
  logic [IW-1:0]          dec_slot;
  logic [LW-1:0]          dec_limit;

  logic                   page_we;
  logic                   rank_we;
  logic [RW-1:0]          rank_wdata;

  // Handshake terms
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign issue     = (rd_idx < n_act);
  assign pass_done = !issue && !chk_vld;
  assign chk_valid_bit = frame_valid[chk_idx];

  // Active frame count from the register: zero means one, clamp to FRAMES
  always_comb begin
    if (frame_count == '0) begin
      n_req = CW'(1);
    end else if (32'(frame_count) > 32'(FRAMES)) begin
      n_req = CW'(FRAMES);
    end else begin
      n_req = CW'(frame_count);
    end
  end

  // Outcome of the search pass
  always_comb begin
    dec_hit   = hit_found;
    dec_repl  = 1'b0;
    dec_slot  = max_idx;
    dec_limit = LIMIT_FULL;
    if (hit_found) begin
      dec_slot  = hit_idx;
      dec_limit = {1'b0, hit_rank};
    end else if (empty_found) begin
      dec_slot = empty_idx;
    end else begin
      dec_repl = 1'b1;
    end
  end

  // Page store write: miss fills the chosen frame at the end of the search
  assign page_we = (state == ST_SCAN) && pass_done && !dec_hit;

  // Rank update: chosen frame goes to zero, others age below the limit
  always_comb begin
    rank_wdata = rank_rdata + RW'(1);
    rank_we    = 1'b0;
    if ((state == ST_UPDATE) && chk_vld) begin
      if (chk_idx == slot_idx) begin
        rank_wdata = '0;
        rank_we    = 1'b1;
      end else if (chk_valid_bit && ({1'b0, rank_rdata} < limit) &&
                   (rank_rdata < RANK_TOP)) begin
        rank_we = 1'b1;
      end
    end
  end

  lru_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (dec_slot),
    .wdata (page_q),
    .raddr (rd_idx[IW-1:0]),
    .rdata (page_rdata)
  );

  lru_ram #(
    .WIDTH (RW),
    .DEPTH (FRAMES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (chk_idx),
    .wdata (rank_wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rank_rdata)
  );

  // Sequencer, frame state, totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frame_count   <= FRAME_COUNT_RESET;
      frame_valid   <= '0;
      hit_counter   <= '0;
      fault_counter <= '0;
      out_valid     <= 1'b0;
      chk_vld       <= 1'b0;
      rd_idx        <= '0;
    end else begin
      if (cfg_we) begin
        frame_count <= cfg_wdata;
      end
      // result leaves; a load in the finish state sets it again
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          chk_vld <= 1'b0;
          if (in_xfer) begin
            page_q      <= page;
            n_act       <= n_req;
            rd_idx      <= '0;
            hit_found   <= 1'b0;
            empty_found <= 1'b0;
            state       <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          chk_vld <= issue;
          chk_idx <= rd_idx[IW-1:0];
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          // evaluate the frame whose data is on the read ports
          if (chk_vld) begin
            if (!hit_found && chk_valid_bit && (page_rdata == page_q)) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_idx;
              hit_rank  <= rank_rdata;
            end
            if (!empty_found && !chk_valid_bit) begin
              empty_found <= 1'b1;
              empty_idx   <= chk_idx;
            end
            if ((chk_idx == '0) || (rank_rdata > max_rank)) begin
              max_idx  <= chk_idx;
              max_rank <= rank_rdata;
              max_page <= page_rdata;
            end
          end
          if (pass_done) begin
            is_hit    <= dec_hit;
            is_repl   <= dec_repl;
            slot_idx  <= dec_slot;
            limit     <= dec_limit;
            repl_page <= dec_repl ? max_page : '0;
            if (!dec_hit) begin
              frame_valid[dec_slot] <= 1'b1;
            end
            rd_idx <= '0;
            state  <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          chk_vld <= issue;
          chk_idx <= rd_idx[IW-1:0];
          if (issue) begin
            rd_idx <= rd_idx + CW'(1);
          end
          if (pass_done) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            hit            <= is_hit;
            slot           <= SLOT_W'(slot_idx);
            replaced_valid <= is_repl;
            replaced_page  <= repl_page;
            if (is_hit) begin
              if (hit_counter != COUNT_MAX) begin
                hit_counter <= hit_counter + COUNT_W'(1);
              end
            end else begin
              if (fault_counter != COUNT_MAX) begin
                fault_counter <= fault_counter + COUNT_W'(1);
              end
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign hits_total   = hit_counter;
  assign faults_total = fault_counter;

  // An accepted transfer always starts a multi-cycle search
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("input not stalled after accepted transfer");

  // A hit never evicts anything
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && replaced_valid))
    else $error("hit reported with an evicted page");

  // No eviction means the evicted page field reads zero
  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !replaced_valid) |-> (replaced_page == '0))
    else $error("evicted page nonzero without eviction");

  // Totals only move when a result is loaded
  a_totals_stable: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FINISH) |=> ($stable(hit_counter) && $stable(fault_counter)))
    else $error("totals changed outside result load");

  // The read pointer never runs past the active frame count
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) || (state == ST_UPDATE)) |-> (rd_idx <= n_act))
    else $error("read pointer beyond active frames");

endmodule : lru_page_replacement_unit

`default_nettype wire

[sim/tb_lru_page_replacement_unit.sv]
// tb_lru_page_replacement_unit: self-checking testbench for the LRU page replacement unit.
// Depends on lru_pkg and lru_page_replacement_unit; drives page references, compares
// every result against an in-bench LRU predictor and varies the frame count between phases.
`timescale 1ns / 1ps

module tb_lru_page_replacement_unit;

  import lru_pkg::*;

  localparam int unsigned FRAMES        = 8;
  localparam int unsigned PAGE_BITS     = 16;
  localparam int unsigned SETTLE_CYCLES = 2 * FRAMES + 6;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_REFS   = 1850;
  localparam int unsigned POOL_SIZE     = 12;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 replaced_valid;
    logic [PAGE_BITS-1:0] replaced_page;
    logic [COUNT_W-1:0]   hits_total;
    logic [COUNT_W-1:0]   faults_total;
  } lru_result_t;

  // LRU predictor plus the queue of results still owed by the block
  class lru_scoreboard;
    page_t                     frame_page [FRAMES];
    bit                        frame_used [FRAMES];
    int unsigned               frame_age  [FRAMES];
    logic [COUNT_W-1:0]        hit_count;
    logic [COUNT_W-1:0]        fault_count;
    logic [FRAME_COUNT_W-1:0]  frame_count;
    lru_result_t               owed_results[$];
    int unsigned               errors;

    function new();
      foreach (frame_used[j]) begin
        frame_used[j] = 1'b0;
        frame_age[j]  = 0;
        frame_page[j] = '0;
      end
      hit_count   = '0;
      fault_count = '0;
      frame_count = FRAME_COUNT_RESET;
      errors      = 0;
    endfunction

    function void set_frame_count(logic [FRAME_COUNT_W-1:0] value);
      frame_count = value;
    endfunction

    function int unsigned active_frames();
      if (frame_count == 0) return 1;
      if (frame_count > FRAMES) return FRAMES;
      return frame_count;
    endfunction

    // age valid active frames younger than limit, then mark used as most recent
    function void age_frames(int unsigned used, int unsigned limit, int unsigned n);
      for (int unsigned j = 0; j < n; j++) begin
        if (j != used && frame_used[j] && frame_age[j] < limit && frame_age[j] < FRAMES - 1)
          frame_age[j]++;
      end
      frame_age[used] = 0;
    endfunction

    // accepted reference: advance the predictor and queue the expected result
    function void note_reference(page_t pg);
      lru_result_t r;
      int unsigned n;
      bit          found;
      n     = active_frames();
      found = 1'b0;
      r     = '0;
      for (int unsigned j = 0; j < n && !found; j++) begin
        if (frame_used[j] && frame_page[j] == pg) begin
          found = 1'b1;
          r.slot = SLOT_W'(j);
        end
      end
      if (found) begin
        r.hit = 1'b1;
        if (hit_count != COUNT_MAX) hit_count++;
        age_frames(r.slot, frame_age[r.slot], n);
      end else begin
        if (fault_count != COUNT_MAX) fault_count++;
        for (int unsigned j = 0; j < n && !found; j++) begin
          if (!frame_used[j]) begin
            found = 1'b1;
            r.slot = SLOT_W'(j);
          end
        end
        if (!found) begin
          // evict the oldest; ties go to the lowest frame
          r.slot = '0;
          for (int unsigned j = 1; j < n; j++)
            if (frame_age[j] > frame_age[r.slot]) r.slot = SLOT_W'(j);
          r.replaced_valid = 1'b1;
          r.replaced_page  = frame_page[r.slot];
        end
        frame_page[r.slot] = pg;
        frame_used[r.slot] = 1'b1;
        age_frames(r.slot, FRAMES, n);
      end
      r.hits_total   = hit_count;
      r.faults_total = fault_count;
      owed_results.push_back(r);
    endfunction

    // transferred result: compare field by field with the oldest expectation
    function void check_result(lru_result_t got);
      lru_result_t exp_r;
      if (owed_results.size() == 0) begin
        $error("result transfer with no reference outstanding");
        errors++;
        return;
      end
      exp_r = owed_results.pop_front();
      if (got.hit !== exp_r.hit) begin
        $error("hit: expected %0d, got %0d", exp_r.hit, got.hit);
        errors++;
      end
      if (got.slot !== exp_r.slot) begin
        $error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
        errors++;
      end
      if (got.replaced_valid !== exp_r.replaced_valid) begin
        $error("replaced_valid: expected %0d, got %0d", exp_r.replaced_valid,
               got.replaced_valid);
        errors++;
      end
      if (got.replaced_page !== exp_r.replaced_page) begin
        $error("replaced_page: expected %h, got %h", exp_r.replaced_page, got.replaced_page);
        errors++;
      end
      if (got.hits_total !== exp_r.hits_total) begin
        $error("hits_total: expected %0d, got %0d", exp_r.hits_total, got.hits_total);
        errors++;
      end
      if (got.faults_total !== exp_r.faults_total) begin
        $error("faults_total: expected %0d, got %0d", exp_r.faults_total, got.faults_total);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [FRAME_COUNT_W-1:0]  cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  page_t                     page;
  logic                      out_valid;
  logic                      out_stall;
  logic                      hit;
  logic [SLOT_W-1:0]         slot;
  logic                      replaced_valid;
  page_t                     replaced_page;
  logic [COUNT_W-1:0]        hits_total;
  logic [COUNT_W-1:0]        faults_total;

  int unsigned               hold_requests;
  lru_scoreboard             sb;
  lru_result_t               observed;

  lru_page_replacement_unit #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .page           (page),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .slot           (slot),
    .replaced_valid (replaced_valid),
    .replaced_page  (replaced_page),
    .hits_total     (hits_total),
    .faults_total   (faults_total)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // input transfers feed the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_reference(page);
  end

  // output transfers are checked
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      observed.hit            = hit;
      observed.slot           = slot;
      observed.replaced_valid = replaced_valid;
      observed.replaced_page  = replaced_page;
      observed.hits_total     = hits_total;
      observed.faults_total   = faults_total;
      sb.check_result(observed);
    end
  end

  // result side: stall pattern changes every segment; long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned holds_done;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(1, 64);
      repeat (seg) begin
        @(posedge clk);
        if (hold_requests != holds_done) begin
          holds_done++;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // offer one reference and hold it until the transfer
  task automatic send_page(page_t pg);
    in_valid <= 1'b1;
    page     <= pg;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_gap(int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop offering and wait until every expected result has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [FRAME_COUNT_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_frame_count(value);
  endtask

  // bursts of references, mostly from a small page pool so hits and evictions occur
  task automatic run_references(int unsigned n_refs);
    page_t       pool [POOL_SIZE];
    int unsigned span;
    int unsigned sent;
    int unsigned burst;
    foreach (pool[i]) pool[i] = page_t'($urandom);
    span = sb.active_frames() + $urandom_range(1, 4);
    if (span > POOL_SIZE) span = POOL_SIZE;
    sent = 0;
    while (sent < n_refs) begin
      burst = $urandom_range(1, 24);
      for (int unsigned k = 0; k < burst && sent < n_refs; k++) begin
        if ($urandom_range(0, 9) < 8)
          send_page(pool[$urandom_range(0, span - 1)]);
        else
          send_page(page_t'($urandom));
        sent++;
      end
      if ($urandom_range(0, 2) != 0)
        sender_gap($urandom_range(1, 12));
    end
  endtask

  initial begin
    logic [FRAME_COUNT_W-1:0] plan [7];
    logic [FRAME_COUNT_W-1:0] fc;
    int unsigned              total;
    int unsigned              phase;
    int unsigned              n;
    sb            = new();
    hold_requests = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    page          = '0;
    plan          = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd2, 4'd9};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill all frames, extremes of page, hit, eviction
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    for (int unsigned p = 1; p <= 6; p++) send_page(page_t'(p));
    send_page(16'h0002);
    send_page(16'h8000);
    // shrink to two frames: resident page in an inactive frame misses and is duplicated
    write_frame_count(4'd2);
    send_page(16'h0005);
    send_page(16'h0005);
    send_page(16'h0001);
    // grow back: stale frames visible again, lowest duplicate hits
    write_frame_count(4'd8);
    send_page(16'h0001);
    send_page(16'h0005);
    // zero count acts as one frame
    write_frame_count(4'd0);
    send_page(16'h0007);
    send_page(16'h0007);
    send_page(16'h0009);
    // counts above the frame total clamp
    write_frame_count(4'd15);
    send_page(16'h0009);
    send_page(16'h7FFF);
    write_frame_count(4'd9);
    send_page(16'h0003);

    // random phases over a spread of frame counts
    total = 0;
    phase = 0;
    while (total < RANDOM_REFS) begin
      fc = (phase < 7) ? plan[phase] : FRAME_COUNT_W'($urandom_range(0, 15));
      write_frame_count(fc);
      n = $urandom_range(120, 260);
      if (phase == 1) begin
        // receiver holds off while references keep coming back to back
        hold_requests <= hold_requests + 1;
        repeat (24) send_page(page_t'($urandom));
        total += 24;
      end
      if (phase == 3) begin
        run_references(n / 2);
        wait_drained();
        run_references(n - n / 2);
      end else begin
        run_references(n);
      end
      total += n;
      phase++;
    end

    wait_drained();
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
